>>> rtl/core/apf_pkg.sv
// ============================================================================
// apf_pkg
// Shared types and constants for the articulation point finder.
// ============================================================================
package apf_pkg;

    // width of a vertex field on the ports and in a stored edge
    localparam int VTX_W     = 6;
    localparam int EDGE_W    = 2 * VTX_W;

    // cap on results reported by one run
    localparam int MAX_OUT   = 64;
    localparam int RES_CNT_W = $clog2(MAX_OUT + 1);

    // input commands
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    // search sequencer states
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_EDGE = 7'b0000100,
        S_BACK = 7'b0001000,
        S_POP  = 7'b0010000,
        S_PUSH = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

endpackage

>>> rtl/core/articulation_point_finder.sv
// ============================================================================
// articulation_point_finder
// Cut vertex search over an undirected edge list with a depth-first sequencer.
// ============================================================================
// Edge words (command add) are taken one per cycle and stored in load order.
// A run word starts a depth-first search from vertex 0; input is stalled until
// the run's last result is loaded into the output register. Every visited
// vertex scans the whole stored edge list through the single read port of
// the edge memory, each stored edge passing a scan state and an edge state
// (and a back state on a back edge). Vertex records live in two memories
// (discovery time; full record of discovery time, low time, parent, scan
// position and tally, the child count at the root and a cut flag elsewhere);
// the record of the vertex on top of the search is held in registers and
// written back when the search descends. No clearing pass is needed after
// reset. Results come out in the order the search finishes vertices, the last
// one flagged; a run with no cut vertex gives a single none-found word.
// ============================================================================
module articulation_point_finder #(
    parameter int VERTICES = 64,
    parameter int EDGES    = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [apf_pkg::VTX_W-1:0] i_vertex_a,
    input  logic [apf_pkg::VTX_W-1:0] i_vertex_b,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [apf_pkg::VTX_W-1:0] o_cut_vertex,
    output logic                      o_none_found,
    output logic                      o_edges_dropped,
    output logic                      o_last
);

    localparam int VW    = $clog2(VERTICES);
    localparam int EW    = $clog2(EDGES + 1);
    localparam int EAW   = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int TW    = $clog2(VERTICES + 2);
    localparam int REC_W = 3 * TW + VW + EW;
    localparam int FW    = apf_pkg::VTX_W;
    localparam int RW    = apf_pkg::RES_CNT_W;

    apf_pkg::t_state r_state, n_state;

    logic [EW-1:0]       r_edge_cnt, n_edge_cnt;
    logic                r_ovf, n_ovf;
    logic [VERTICES-1:0] r_visited, n_visited;
    logic [TW-1:0]       r_time, n_time;

    // record of the vertex on top of the search
    logic [VW-1:0]       r_u, n_u;
    logic [TW-1:0]       r_disc, n_disc;
    logic [TW-1:0]       r_low, n_low;
    logic [VW-1:0]       r_par, n_par;
    logic [EW-1:0]       r_scan, n_scan;
    logic [TW-1:0]       r_tally, n_tally;

    // result staging
    logic [VW-1:0]       r_res_v, n_res_v;
    logic                r_at_root, n_at_root;
    logic                r_pend_valid, n_pend_valid;
    logic [VW-1:0]       r_pend_v, n_pend_v;
    logic [RW-1:0]       r_n_res, n_n_res;

    logic                r_out_valid, n_out_valid;
    logic [FW-1:0]       r_out_cut, n_out_cut;
    logic                r_out_none, n_out_none;
    logic                r_out_drop, n_out_drop;
    logic                r_out_last, n_out_last;

    // memory ports
    logic                      edge_we;
    logic [apf_pkg::EDGE_W-1:0] edge_rd;
    logic                      disc_we;
    logic [VW-1:0]             disc_waddr;
    logic [TW-1:0]             disc_wdata;
    logic [TW-1:0]             disc_rd;
    logic                      rec_we;
    logic [REC_W-1:0]          rec_wdata;
    logic [REC_W-1:0]          rec_rd;

    // decoded edge and parent record
    logic [FW-1:0] ea, eb, v_raw;
    logic          incident, v_ok;
    logic [VW-1:0] v_idx;
    logic [TW-1:0] p_disc, p_low, p_tally;
    logic [VW-1:0] p_par;
    logic [EW-1:0] p_scan;

    logic in_acc, in_ok, out_free;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign in_ok    = (int'(i_vertex_a) < VERTICES) && (int'(i_vertex_b) < VERTICES);
    assign out_free = !r_out_valid || !i_out_stall;

    assign edge_we  = in_acc && (i_command == apf_pkg::CMD_ADD) && in_ok
                      && (r_edge_cnt < EW'(EDGES));

    assign ea       = edge_rd[apf_pkg::EDGE_W-1:FW];
    assign eb       = edge_rd[FW-1:0];
    assign incident = (int'(ea) == int'(r_u)) || (int'(eb) == int'(r_u));
    assign v_raw    = (int'(ea) == int'(r_u)) ? eb : ea;
    assign v_ok     = int'(v_raw) < VERTICES;
    assign v_idx    = VW'(v_raw);

    assign {p_disc, p_low, p_par, p_scan, p_tally} = rec_rd;

    // edge list in load order
    apf_ram #(.WIDTH(apf_pkg::EDGE_W), .DEPTH(EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_edge_cnt[EAW-1:0]),
        .i_wdata ({i_vertex_a, i_vertex_b}),
        .i_raddr (r_scan[EAW-1:0]),
        .o_rdata (edge_rd)
    );

    // discovery time per vertex
    apf_ram #(.WIDTH(TW), .DEPTH(VERTICES)) u_disc_ram (
        .i_clk   (i_clk),
        .i_we    (disc_we),
        .i_waddr (disc_waddr),
        .i_wdata (disc_wdata),
        .i_raddr (v_idx),
        .o_rdata (disc_rd)
    );

    // full record per vertex, written when the search descends
    apf_ram #(.WIDTH(REC_W), .DEPTH(VERTICES)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_u),
        .i_wdata (rec_wdata),
        .i_raddr (r_par),
        .o_rdata (rec_rd)
    );

    // search sequencer
    always_comb begin
        n_state      = r_state;
        n_edge_cnt   = r_edge_cnt;
        n_ovf        = r_ovf;
        n_visited    = r_visited;
        n_time       = r_time;
        n_u          = r_u;
        n_disc       = r_disc;
        n_low        = r_low;
        n_par        = r_par;
        n_scan       = r_scan;
        n_tally      = r_tally;
        n_res_v      = r_res_v;
        n_at_root    = r_at_root;
        n_pend_valid = r_pend_valid;
        n_pend_v     = r_pend_v;
        n_n_res      = r_n_res;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_cut    = r_out_cut;
        n_out_none   = r_out_none;
        n_out_drop   = r_out_drop;
        n_out_last   = r_out_last;
        disc_we      = 1'b0;
        disc_waddr   = v_idx;
        disc_wdata   = r_time;
        rec_we       = 1'b0;
        rec_wdata    = {r_disc, r_low, r_par, r_scan + EW'(1), r_tally};

        unique case (r_state)
            apf_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_command == apf_pkg::CMD_ADD) begin
                        if (in_ok) begin
                            if (r_edge_cnt < EW'(EDGES)) begin
                                n_edge_cnt = r_edge_cnt + EW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end else begin
                        // discover the root
                        n_visited    = '0;
                        n_visited[0] = 1'b1;
                        n_u          = '0;
                        n_disc       = TW'(1);
                        n_low        = TW'(1);
                        n_par        = '0;
                        n_scan       = '0;
                        n_tally      = '0;
                        n_time       = TW'(2);
                        n_at_root    = 1'b0;
                        n_pend_valid = 1'b0;
                        n_n_res      = '0;
                        disc_we      = 1'b1;
                        disc_waddr   = '0;
                        disc_wdata   = TW'(1);
                        n_state      = apf_pkg::S_SCAN;
                    end
                end
            end
            apf_pkg::S_SCAN: begin
                if (r_scan < r_edge_cnt) begin
                    n_state = apf_pkg::S_EDGE;
                end else if (r_u == '0) begin
                    n_at_root = 1'b1;
                    n_res_v   = '0;
                    n_state   = (r_tally > TW'(1)) ? apf_pkg::S_PUSH : apf_pkg::S_FIN;
                end else begin
                    n_res_v = r_u;
                    n_state = apf_pkg::S_POP;
                end
            end
            apf_pkg::S_EDGE: begin
                n_scan  = r_scan + EW'(1);
                n_state = apf_pkg::S_SCAN;
                if (!incident || !v_ok || v_idx == r_u
                    || (r_u != '0 && v_idx == r_par)) begin
                    n_state = apf_pkg::S_SCAN;
                end else if (r_visited[v_idx]) begin
                    n_state = apf_pkg::S_BACK;
                end else begin
                    // descend: save current record, start the child
                    rec_we           = 1'b1;
                    disc_we          = 1'b1;
                    n_visited[v_idx] = 1'b1;
                    n_u              = v_idx;
                    n_disc           = r_time;
                    n_low            = r_time;
                    n_par            = r_u;
                    n_scan           = '0;
                    n_tally          = '0;
                    n_time           = r_time + TW'(1);
                end
            end
            apf_pkg::S_BACK: begin
                if (disc_rd < r_low) begin
                    n_low = disc_rd;
                end
                n_state = apf_pkg::S_SCAN;
            end
            apf_pkg::S_POP: begin
                // fold the finished child into its parent
                n_u    = r_par;
                n_disc = p_disc;
                n_par  = p_par;
                n_scan = p_scan;
                n_low  = (r_low < p_low) ? r_low : p_low;
                if (r_par != '0) begin
                    n_tally = (r_low >= p_disc) ? TW'(1) : p_tally;
                end else begin
                    n_tally = p_tally + TW'(1);
                end
                n_state = (r_tally != '0) ? apf_pkg::S_PUSH : apf_pkg::S_SCAN;
            end
            apf_pkg::S_PUSH: begin
                // one result is held back so the final one can carry last
                if (r_n_res == RW'(apf_pkg::MAX_OUT)) begin
                    n_state = r_at_root ? apf_pkg::S_FIN : apf_pkg::S_SCAN;
                end else if (!r_pend_valid) begin
                    n_pend_valid = 1'b1;
                    n_pend_v     = r_res_v;
                    n_n_res      = r_n_res + RW'(1);
                    n_state      = r_at_root ? apf_pkg::S_FIN : apf_pkg::S_SCAN;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cut   = FW'(r_pend_v);
                    n_out_none  = 1'b0;
                    n_out_drop  = r_ovf;
                    n_out_last  = 1'b0;
                    n_pend_v    = r_res_v;
                    n_n_res     = r_n_res + RW'(1);
                    n_state     = r_at_root ? apf_pkg::S_FIN : apf_pkg::S_SCAN;
                end
            end
            apf_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_cut    = r_pend_valid ? FW'(r_pend_v) : '0;
                    n_out_none   = !r_pend_valid;
                    n_out_drop   = r_ovf;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_edge_cnt   = '0;
                    n_ovf        = 1'b0;
                    n_state      = apf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = apf_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= apf_pkg::S_IDLE;
            r_edge_cnt   <= '0;
            r_ovf        <= 1'b0;
            r_time       <= TW'(1);
            r_at_root    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_n_res      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edge_cnt   <= n_edge_cnt;
            r_ovf        <= n_ovf;
            r_time       <= n_time;
            r_at_root    <= n_at_root;
            r_pend_valid <= n_pend_valid;
            r_n_res      <= n_n_res;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_visited  <= n_visited;
        r_u        <= n_u;
        r_disc     <= n_disc;
        r_low      <= n_low;
        r_par      <= n_par;
        r_scan     <= n_scan;
        r_tally    <= n_tally;
        r_res_v    <= n_res_v;
        r_pend_v   <= n_pend_v;
        r_out_cut  <= n_out_cut;
        r_out_none <= n_out_none;
        r_out_drop <= n_out_drop;
        r_out_last <= n_out_last;
    end

    assign o_in_stall      = (r_state != apf_pkg::S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cut_vertex    = r_out_cut;
    assign o_none_found    = r_out_none;
    assign o_edges_dropped = r_out_drop;
    assign o_last          = r_out_last;

    // result count never passes the cap
    a_res_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_n_res) <= apf_pkg::MAX_OUT)
        else $error("result count above cap");

    // a held result has been counted
    a_pend_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_n_res != '0))
        else $error("held result not counted");

    // end of run loads the final word and empties the store
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == apf_pkg::S_FIN && out_free)
        |=> (o_out_valid && o_last && r_edge_cnt == '0 && !r_ovf))
        else $error("run end did not finish cleanly");

    // stored edge count stays within capacity
    a_edge_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_edge_cnt) <= EDGES)
        else $error("edge count above capacity");

endmodule

>>> rtl/core/apf_ram.sv
// ============================================================================
// apf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
